FILE: hdl/lsa_pkg.sv
`default_nettype none
package lsa_pkg;

  localparam int MAX_POINTS_DEF = 1024;

  localparam int EXP_BITS = 16;
  localparam logic [31:0] K_LORENTZ = 32'd1367130551;
  localparam logic [31:0] K_GAUSS = 32'd2017426194;

  localparam int ACC_W = 48;
  localparam int DIV_W = 64;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_LOR_ABS  = 2'd0,
    KIND_LOR_DISP = 2'd1,
    KIND_GAUSS    = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_FIELD_START = 2'd0,
    REG_FIELD_STEP  = 2'd1,
    REG_POINTS_USED = 2'd2,
    REG_NONE        = 2'd3
  } reg_index_t;

  typedef logic [63:0] pow_tab_t [0:EXP_BITS];

  // t[j] = 2^(-2^-j) in q0.32, each entry the integer square root of the last times 2^32
  function automatic pow_tab_t make_pow_tab();
    pow_tab_t t;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    t[0] = 64'h8000_0000;
    for (int j = 1; j <= EXP_BITS; j++) begin
      n = t[j-1] << 32;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int k = 0; k < 32; k++) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      t[j] = r;
    end
    return t;
  endfunction

  localparam pow_tab_t POW_TAB = make_pow_tab();

endpackage
`default_nettype wire

FILE: hdl/lsa_ram.sv
`default_nettype none
module lsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/lsa_div.sv
`default_nettype none
// radix-2 restoring divider, one quotient bit a cycle
module lsa_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [lsa_pkg::DIV_W-1:0]     dividend,
  input  wire logic [lsa_pkg::DIV_W-2:0]     divisor,
  output logic                               done,
  output logic      [lsa_pkg::DIV_W-1:0]     quotient
);

  localparam int W = lsa_pkg::DIV_W;
  localparam int CW = $clog2(W + 1);

  logic [W-2:0]  rem;
  logic [W-2:0]  dsr;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rsh;
  logic          fits;

  assign rsh = {rem, quotient[W-1]};
  assign fits = rsh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        dsr <= divisor;
        quotient <= dividend;
        cnt <= CW'(W);
      end else if (cnt != '0) begin
        rem <= fits ? (W-1)'(rsh - {1'b0, dsr}) : rsh[W-2:0];
        quotient <= {quotient[W-2:0], fits};
        cnt <= cnt - 1'b1;
        done <= (cnt == CW'(1));
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/lineshape_spectrum_accumulator_core.sv
`default_nettype none
// Spectrum of MAX_POINTS signed q24.24 accumulators (a 49-bit wide RAM holding the
// value and a saturation mark) over the axis field_start + i*field_step. An add item
// walks points 0 .. min(points_used, MAX_POINTS)-1 one at a time through one shared
// 64-bit radix-2 divider and one shared 33x32 multiplier. Each divide holds its state
// from the start strobe through the quotient bits to done. A Gaussian line takes two
// divides per point and 16 multiply steps for the exponential, a Lorentzian line takes
// three divides, and dispersion adds the S_DISP multiply step. A read gives one item,
// its value registered from the RAM; a clear, and the pass that follows reset, write
// zero to all MAX_POINTS entries at one a cycle. The input is stalled while any of
// this runs and while a read result is not yet taken.
module lineshape_spectrum_accumulator_core #(
  parameter int MAX_POINTS = lsa_pkg::MAX_POINTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         mode,
  input  wire logic [1:0]         kind,
  input  wire logic signed [31:0] center,
  input  wire logic [30:0]        line_width,
  input  wire logic signed [31:0] amplitude,
  input  wire logic [9:0]         point_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [9:0]              read_index,
  output logic signed [47:0]      intensity,
  output logic                    saturated,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int RW = lsa_pkg::ACC_W + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_PT, S_XDIV, S_X2, S_GEXP, S_GSH,
    S_LDIV, S_DISP, S_KS, S_AMUL, S_TDIV, S_ACC
  } state_t;

  state_t state;

  logic signed [31:0] field_start;
  logic signed [31:0] field_step;
  logic [10:0]        points_used;

  logic [1:0]         ln_kind;
  logic signed [31:0] ln_center;
  logic [30:0]        ln_w;
  logic [32:0]        amag;
  logic               amp_neg;
  logic [CW-1:0]      n;
  logic [CW-1:0]      i;
  logic signed [49:0] f;
  logic [48:0]        dmag;
  logic               xneg;
  logic [30:0]        xmag;
  logic [61:0]        x2;
  logic [30:0]        v;
  logic [4:0]         gj;
  logic [31:0]        s;
  logic [31:0]        ks;
  logic [63:0]        prod;
  logic               neg;
  logic [9:0]         ridx;
  logic               div_start;

  logic               in_acc;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [RW-1:0]      wdata;
  logic               re;
  logic [AW-1:0]      raddr;
  logic [RW-1:0]      rdata;

  logic [63:0]        div_dvd;
  logic [62:0]        div_dsr;
  logic               div_done;
  logic [63:0]        div_q;

  logic [32:0]        mul_a;
  logic [31:0]        mul_b;
  logic [64:0]        mul_p;

  logic signed [49:0] d;
  logic [5:0]         gbit;
  logic [31:0]        disp_s;
  logic [56:0]        term;
  logic signed [58:0] acc_s;
  logic signed [58:0] sum;
  logic               sum_sat;
  logic [47:0]        sum_cl;
  logic [CW-1:0]      n_new;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE) || out_valid;
  assign in_acc = in_valid && !in_stall;

  lsa_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  lsa_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd),
    .divisor(div_dsr), .done(div_done), .quotient(div_q)
  );

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_X2: begin
        mul_a = {2'b0, xmag};
        mul_b = {1'b0, xmag};
      end
      S_GEXP: begin
        mul_a = {2'b0, v};
        mul_b = lsa_pkg::POW_TAB[gj][31:0];
      end
      S_DISP: begin
        mul_a = {2'b0, xmag};
        mul_b = s;
      end
      S_KS: begin
        mul_a = {1'b0, (ln_kind == lsa_pkg::KIND_GAUSS) ? lsa_pkg::K_GAUSS
                                                          : lsa_pkg::K_LORENTZ};
        mul_b = s;
      end
      S_AMUL: begin
        mul_a = amag;
        mul_b = ks;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    div_dvd = prod;
    div_dsr = {24'b0, ln_w, 8'b0};
    unique case (state)
      S_XDIV: begin
        div_dvd = {dmag[46:0], 17'b0};
        div_dsr = {32'b0, ln_w};
      end
      S_LDIV: begin
        div_dvd = 64'h4000_0000_0000_0000;
        div_dsr = {1'b0, x2} + 63'h1_0000_0000;
      end
      default: begin
        div_dvd = prod;
        div_dsr = {24'b0, ln_w, 8'b0};
      end
    endcase
  end

  assign d = f - {{18{ln_center[31]}}, ln_center};
  assign gbit = 6'd32 - {1'b0, gj};
  assign disp_s = mul_p[47:16];
  assign term = (div_q > 64'h0100_0000_0000_0000) ? 57'h100_0000_0000_0000 : div_q[56:0];
  assign acc_s = {{11{rdata[47]}}, rdata[47:0]};
  assign sum = neg ? acc_s - $signed({2'b0, term}) : acc_s + $signed({2'b0, term});
  assign sum_sat = (sum[58:47] != {12{sum[58]}});
  assign sum_cl = sum_sat ? (sum[58] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF) : sum[47:0];
  assign n_new = (32'(points_used) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(points_used);

  always_comb begin
    we = 1'b0;
    waddr = i[AW-1:0];
    wdata = '0;
    re = 1'b0;
    raddr = i[AW-1:0];
    if (state == S_CLEAR) begin
      we = 1'b1;
    end else if (state == S_ACC) begin
      we = 1'b1;
      wdata = {rdata[48] | sum_sat, sum_cl};
    end else if (state == S_PT) begin
      re = 1'b1;
    end else if (state == S_IDLE) begin
      re = in_acc && (mode == lsa_pkg::MODE_READ);
      raddr = AW'(point_index);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      i <= '0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      field_start <= '0;
      field_step <= 32'sd65536;
      points_used <= 11'd1024;
    end else begin
      div_start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lsa_pkg::REG_FIELD_START: field_start <= cfg_data;
          lsa_pkg::REG_FIELD_STEP:  field_step <= cfg_data;
          lsa_pkg::REG_POINTS_USED: points_used <= cfg_data[10:0];
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          i <= i + 1'b1;
          if (i == CW'(MAX_POINTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            ln_kind <= kind;
            ln_center <= center;
            ln_w <= (line_width == '0) ? 31'd1 : line_width;
            amag <= amplitude[31] ? {1'b0, 32'(-amplitude)} << 1 : {1'b0, amplitude} << 1;
            amp_neg <= amplitude[31];
            n <= n_new;
            i <= '0;
            f <= {{18{field_start[31]}}, field_start};
            ridx <= point_index;
            unique case (mode)
              lsa_pkg::MODE_ADD: begin
                if (kind != lsa_pkg::KIND_NONE && n_new != '0) begin
                  state <= S_PT;
                end
              end
              lsa_pkg::MODE_READ:  state <= S_RD;
              lsa_pkg::MODE_CLEAR: state <= S_CLEAR;
              default: ;
            endcase
          end
        end
        S_RD: begin
          read_index <= ridx;
          if (32'(ridx) < MAX_POINTS) begin
            intensity <= rdata[47:0];
            saturated <= rdata[48];
          end else begin
            intensity <= '0;
            saturated <= 1'b0;
          end
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_PT: begin
          dmag <= d[49] ? 49'(-d) : d[48:0];
          xneg <= d[49];
          neg <= amp_neg;
          div_start <= 1'b1;
          state <= S_XDIV;
        end
        S_XDIV: begin
          if (div_done) begin
            xmag <= (div_q > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : div_q[30:0];
            state <= S_X2;
          end
        end
        S_X2: begin
          x2 <= mul_p[61:0];
          if (ln_kind == lsa_pkg::KIND_GAUSS) begin
            v <= 31'h4000_0000;
            gj <= 5'd1;
            state <= S_GEXP;
          end else begin
            div_start <= 1'b1;
            state <= S_LDIV;
          end
        end
        S_GEXP: begin
          if (x2[gbit]) begin
            v <= mul_p[62:32];
          end
          gj <= gj + 1'b1;
          if (gj == 5'(lsa_pkg::EXP_BITS)) begin
            state <= S_GSH;
          end
        end
        S_GSH: begin
          s <= (x2[61:32] >= 30'd31) ? 32'd0 : {1'b0, v >> x2[36:32]};
          state <= S_KS;
        end
        S_LDIV: begin
          if (div_done) begin
            s <= div_q[31:0];
            state <= (ln_kind == lsa_pkg::KIND_LOR_DISP) ? S_DISP : S_KS;
          end
        end
        S_DISP: begin
          s <= disp_s;
          if (xneg && disp_s != '0) begin
            neg <= !neg;
          end
          state <= S_KS;
        end
        S_KS: begin
          ks <= mul_p[61:30];
          state <= S_AMUL;
        end
        S_AMUL: begin
          prod <= mul_p[63:0];
          div_start <= 1'b1;
          state <= S_TDIV;
        end
        S_TDIV: begin
          if (div_done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          i <= i + 1'b1;
          f <= f + {{18{field_step[31]}}, field_step};
          state <= (i + 1'b1 == n) ? S_IDLE : S_PT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
